### rtl/sfr_pkg.sv
package sfr_pkg;

    // Kinds of result item.
    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_BAD_SUM = 2'd1,
        KIND_BAD_LEN = 2'd2,
        KIND_TIMEOUT = 2'd3
    } t_kind;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_SEED    = 2'd0;
    localparam logic [1:0] REG_MAX_LEN = 2'd1;
    localparam logic [1:0] REG_TIMEOUT = 2'd2;

    localparam logic [7:0]  SEED_RESET    = 8'h0E;
    localparam logic [5:0]  MAX_LEN_RESET = 6'd60;
    localparam logic [15:0] TIMEOUT_RESET = 16'd500;

    // Largest value the 6-bit length fields can carry.
    localparam logic [5:0] LEN_SAT = 6'd63;

    // Entries of the queue between the parser and the sender.
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [7:0]  seed;
        logic [5:0]  max_length;
        logic [15:0] timeout;
    } t_cfg;

    // One unit of work for the sender.
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  command;
        logic [5:0]  length;
    } t_job;

    // Write port of the payload buffer.
    typedef struct packed {
        logic        en;
        logic [5:0]  addr;
        logic [7:0]  data;
    } t_ram_wr;

endpackage

### rtl/sfr_if.sv
interface sfr_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] rx_byte;

    modport source (output valid, output func, output rx_byte, input ready);
    modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

interface sfr_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] command;
    logic [5:0] frame_length;
    logic [5:0] byte_index;
    logic [7:0] payload_byte;
    logic       last;

    modport source (
        output valid, output kind, output command, output frame_length,
        output byte_index, output payload_byte, output last, input ready
    );
    modport sink (
        input valid, input kind, input command, input frame_length,
        input byte_index, input payload_byte, input last, output ready
    );
endinterface

### rtl/sfr_front.sv
module sfr_front
    import sfr_pkg::*;
#(
    parameter int PAYLOAD_DEPTH = 64
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_valid,
    output logic    o_ready,
    input  logic    i_func,
    input  logic [7:0] i_rx_byte,
    input  logic    i_q_full,
    output logic    o_push,
    output t_job    o_job,
    output t_ram_wr o_ram_wr,
    input  logic    i_release
);

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_HEADER = 4'b0010,
        PH_DATA   = 4'b0100,
        PH_CHECK  = 4'b1000
    } t_phase;

    localparam bit DEPTH_LIMITS = (PAYLOAD_DEPTH < 64);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_command, n_command;
    logic [5:0]  r_length, n_length;
    logic [5:0]  r_fill, n_fill;
    logic [7:0]  r_sum, n_sum;
    logic [15:0] r_ticks, n_ticks;
    logic        r_busy, n_busy;

    logic        accept;
    logic [5:0]  limit;
    logic [5:0]  fill_inc;

    // The buffer may not take new payload until the sender has drained it.
    assign o_ready = !i_q_full && !((r_phase == PH_DATA) && r_busy);
    assign accept  = i_valid && o_ready;

    assign limit = (DEPTH_LIMITS && (i_cfg.max_length > 6'(PAYLOAD_DEPTH)))
                 ? 6'(PAYLOAD_DEPTH) : i_cfg.max_length;
    assign fill_inc = r_fill + 6'd1;

    always_comb begin
        n_phase   = r_phase;
        n_command = r_command;
        n_length  = r_length;
        n_fill    = r_fill;
        n_sum     = r_sum;
        n_ticks   = r_ticks;
        o_push    = 1'b0;
        o_job     = '{kind: KIND_PAYLOAD, command: r_command, length: r_length};
        o_ram_wr  = '{en: 1'b0, addr: r_fill, data: i_rx_byte};

        if (accept) begin
            if (i_func) begin
                if (r_phase != PH_IDLE) begin
                    if (r_ticks >= i_cfg.timeout) begin
                        o_push     = 1'b1;
                        o_job.kind = KIND_TIMEOUT;
                        n_phase    = PH_IDLE;
                    end else begin
                        n_ticks = r_ticks + 16'd1;
                    end
                end
            end else begin
                case (r_phase)
                    PH_IDLE: begin
                        n_command = i_rx_byte;
                        n_length  = 6'd0;
                        n_fill    = 6'd0;
                        n_ticks   = 16'd0;
                        n_sum     = i_cfg.seed ^ i_rx_byte;
                        n_phase   = PH_HEADER;
                    end
                    PH_HEADER: begin
                        if (i_rx_byte > {2'b00, limit}) begin
                            o_push       = 1'b1;
                            o_job.kind   = KIND_BAD_LEN;
                            o_job.length = (i_rx_byte > {2'b00, LEN_SAT})
                                         ? LEN_SAT : i_rx_byte[5:0];
                            n_phase      = PH_IDLE;
                        end else begin
                            n_length = i_rx_byte[5:0];
                            n_sum    = r_sum ^ i_rx_byte;
                            n_phase  = (i_rx_byte != 8'd0) ? PH_DATA : PH_CHECK;
                        end
                    end
                    PH_DATA: begin
                        o_ram_wr.en = (int'(r_fill) < PAYLOAD_DEPTH);
                        n_sum       = r_sum ^ i_rx_byte;
                        n_fill      = fill_inc;
                        if (fill_inc >= r_length) begin
                            n_phase = PH_CHECK;
                        end
                    end
                    PH_CHECK: begin
                        o_push = 1'b1;
                        if (i_rx_byte != r_sum) begin
                            o_job.kind = KIND_BAD_SUM;
                        end
                        n_phase = PH_IDLE;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // A good frame with payload holds the buffer until its last byte is sent.
    always_comb begin
        n_busy = r_busy;
        if (o_push && (o_job.kind == KIND_PAYLOAD) && (o_job.length != 6'd0)) begin
            n_busy = 1'b1;
        end else if (i_release) begin
            n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_busy  <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_command <= n_command;
        r_length  <= n_length;
        r_fill    <= n_fill;
        r_sum     <= n_sum;
        r_ticks   <= n_ticks;
    end

endmodule

### rtl/sfr_queue.sv
module sfr_queue
    import sfr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_head,
    output logic o_full,
    output logic o_empty
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_job          r_entry [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_entry[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_job;
        end
    end

endmodule

### rtl/sfr_back.sv
module sfr_back
    import sfr_pkg::*;
#(
    parameter int PAYLOAD_DEPTH = 64
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_ram_wr i_ram_wr,
    input  t_job    i_head,
    input  logic    i_empty,
    output logic    o_pop,
    output logic    o_release,
    output logic    o_valid,
    input  logic    i_ready,
    output logic [1:0] o_kind,
    output logic [7:0] o_command,
    output logic [5:0] o_frame_length,
    output logic [5:0] o_byte_index,
    output logic [7:0] o_payload_byte,
    output logic    o_last
);

    localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
    localparam int IW = (AW > 6) ? AW : 6;

    logic [7:0]    mem [PAYLOAD_DEPTH];
    logic [7:0]    r_rd_data;

    logic          r_valid;
    t_kind         r_kind;
    logic [7:0]    r_command;
    logic [5:0]    r_length;
    logic [5:0]    r_index;
    logic          r_use_ram;
    logic          r_last;

    logic          load;
    logic          more;
    logic          rd_en;
    logic [5:0]    rd_index;
    logic [5:0]    n_index;
    logic          head_use_ram;
    logic [IW-1:0] wr_ext;
    logic [IW-1:0] rd_ext;

    // The output register frees up when it is empty or being taken.
    assign load         = !r_valid || i_ready;
    assign more         = r_valid && r_use_ram && !r_last;
    assign n_index      = r_index + 6'd1;
    assign head_use_ram = (i_head.kind == KIND_PAYLOAD) && (i_head.length != 6'd0);

    always_comb begin
        o_pop    = 1'b0;
        rd_en    = 1'b0;
        rd_index = 6'd0;
        if (load) begin
            if (more) begin
                rd_en    = 1'b1;
                rd_index = n_index;
            end else if (!i_empty) begin
                o_pop = 1'b1;
                rd_en = head_use_ram;
            end
        end
    end

    assign wr_ext = IW'(i_ram_wr.addr);
    assign rd_ext = IW'(rd_index);

    always_ff @(posedge i_clk) begin
        if (i_ram_wr.en) begin
            mem[wr_ext[AW-1:0]] <= i_ram_wr.data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_ext[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= more || !i_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (more) begin
                r_index <= n_index;
                r_last  <= ((n_index + 6'd1) == r_length);
            end else if (!i_empty) begin
                r_kind    <= i_head.kind;
                r_command <= i_head.command;
                r_length  <= i_head.length;
                r_index   <= 6'd0;
                r_use_ram <= head_use_ram;
                r_last    <= !head_use_ram || (i_head.length == 6'd1);
            end
        end
    end

    assign o_release      = r_valid && i_ready && r_use_ram && r_last;
    assign o_valid        = r_valid;
    assign o_kind         = r_kind;
    assign o_command      = r_command;
    assign o_frame_length = r_length;
    assign o_byte_index   = r_index;
    assign o_payload_byte = r_use_ram ? r_rd_data : 8'd0;
    assign o_last         = r_last;

endmodule

### rtl/serial_frame_receiver_core.sv
// Serial frame receiver. Input requests are either received bytes (func 0) or
// millisecond ticks (func 1). Bytes form frames of a command byte, a length
// byte, that many payload bytes and a checksum byte, where the checksum is the
// seed XOR the command, the length and every payload byte. A frame with a good
// checksum produces one result request per payload byte (last set on the
// final one), or a single request with zero payload when the length is zero.
// A bad checksum, a length above max_length (or above the buffer depth), and
// a frame that stays open for more than timeout_ticks ticks each produce one
// request of their own kind, and the frame is dropped. A parser in front takes
// one input request per cycle, checks the framing and writes payload into a
// buffer; it hands finished frames and errors through a two-entry queue to a
// sender that drives the output register. Each result passes through the queue
// and then the output register before it can be taken, when the sender is free,
// and the sender then delivers one result per cycle while the output is being
// taken. The parser holds off every input request, ticks included, when the
// queue is full, or while it waits for a payload byte and the previous frame's
// payload is still being sent, because both frames share the single payload
// buffer. No clearing pass runs after reset. Registers on the APB port: 0x0
// checksum_seed (8 bits, reset 0x0E), 0x4 max_length (6 bits, reset 60), 0x8
// timeout_ticks (16 bits, reset 500). They should be written only while the
// block is idle.
module serial_frame_receiver_core
    import sfr_pkg::*;
#(
    parameter int PAYLOAD_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sfr_in_if.sink      i_in,
    sfr_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]  r_seed;
    logic [5:0]  r_max_length;
    logic [15:0] r_timeout;
    logic        cfg_write;
    t_cfg        cfg;

    logic        q_push;
    logic        q_pop;
    logic        q_full;
    logic        q_empty;
    t_job        q_job_in;
    t_job        q_head;
    t_ram_wr     ram_wr;
    logic        buf_release;

    // The configuration port never stalls.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed       <= SEED_RESET;
            r_max_length <= MAX_LEN_RESET;
            r_timeout    <= TIMEOUT_RESET;
        end else if (cfg_write) begin
            case (paddr[3:2])
                REG_SEED:    r_seed       <= pwdata[7:0];
                REG_MAX_LEN: r_max_length <= pwdata[5:0];
                REG_TIMEOUT: r_timeout    <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_SEED:    prdata = {24'd0, r_seed};
            REG_MAX_LEN: prdata = {26'd0, r_max_length};
            REG_TIMEOUT: prdata = {16'd0, r_timeout};
            default:     prdata = 32'd0;
        endcase
    end

    assign cfg = '{seed: r_seed, max_length: r_max_length, timeout: r_timeout};

    // Parser: framing, checksum, length check, timeout and buffer writes.
    sfr_front #(
        .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_valid   (i_in.valid),
        .o_ready   (i_in.ready),
        .i_func    (i_in.func),
        .i_rx_byte (i_in.rx_byte),
        .i_q_full  (q_full),
        .o_push    (q_push),
        .o_job     (q_job_in),
        .o_ram_wr  (ram_wr),
        .i_release (buf_release)
    );

    sfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_job_in),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // Sender: owns the payload buffer and the output register.
    sfr_back #(
        .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ram_wr       (ram_wr),
        .i_head         (q_head),
        .i_empty        (q_empty),
        .o_pop          (q_pop),
        .o_release      (buf_release),
        .o_valid        (o_out.valid),
        .i_ready        (o_out.ready),
        .o_kind         (o_out.kind),
        .o_command      (o_out.command),
        .o_frame_length (o_out.frame_length),
        .o_byte_index   (o_out.byte_index),
        .o_payload_byte (o_out.payload_byte),
        .o_last         (o_out.last)
    );

endmodule
